// ===== rtl/core/stb_pkg.sv =====
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types and constants for the soft timer bank: bank size, opcodes and
// the command / status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package stb_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int SLOT_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int OP_W       = 3;
  localparam int IDX_W      = 3;
  localparam int TIME_W     = 16;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_CREATE = 3'd1,
    OP_DELETE = 3'd2,
    OP_START  = 3'd3,
    OP_STOP   = 3'd4,
    OP_RESET  = 3'd5,
    OP_CHECK  = 3'd6
  } opcode_t;

  typedef logic [SLOT_W-1:0] slot_t;

  // controller -> datapath
  typedef struct packed {
    logic  exec;        // execute the accepted transaction
    logic  sweep;       // advance one slot of a tick sweep
    slot_t sweep_slot;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
  } dp_status_t;

endpackage

// ===== rtl/core/stb_cmd_if.sv =====
// ----------------------------------------------------------------------------
// stb_cmd_if
// Command channel of the soft timer bank: valid / ready plus command payload.
// ----------------------------------------------------------------------------
interface stb_cmd_if;

  logic                        valid;
  logic                        ready;
  logic [stb_pkg::OP_W-1:0]    opcode;
  logic [stb_pkg::IDX_W-1:0]   timer_index;
  logic [stb_pkg::TIME_W-1:0]  timeout_value;

  modport source (output valid, output opcode, output timer_index,
                  output timeout_value, input ready);
  modport sink   (input valid, input opcode, input timer_index,
                  input timeout_value, output ready);

endinterface

// ===== rtl/core/stb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// stb_rsp_if
// Response channel of the soft timer bank: valid / ready plus expired bit.
// ----------------------------------------------------------------------------
interface stb_rsp_if;

  logic valid;
  logic ready;
  logic expired;

  modport source (output valid, output expired, input ready);
  modport sink   (input valid, input expired, output ready);

endinterface

// ===== rtl/core/stb_ctrl.sv =====
// ----------------------------------------------------------------------------
// stb_ctrl
// Controller: command handshake, response valid, and the slot sweep that
// carries out a tick one slot per cycle.
// ----------------------------------------------------------------------------
module stb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  input  stb_pkg::dp_status_t status,
  output stb_pkg::ctl_cmd_t   ctl
);

  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } state_t;

  state_t         state;
  stb_pkg::slot_t slot;
  logic           accept;
  logic           last_slot;

  assign cmd_ready = (state == ST_IDLE) && (!rsp_valid || rsp_ready);
  assign accept    = cmd_valid && cmd_ready;
  assign last_slot = (slot == stb_pkg::SLOT_W'(stb_pkg::NUM_TIMERS - 1));

  assign ctl.exec       = accept;
  assign ctl.sweep      = (state == ST_SWEEP);
  assign ctl.sweep_slot = slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      slot      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // every transaction answers at once; a tick then sweeps the bank
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && status.is_tick) begin
            state <= ST_SWEEP;
            slot  <= '0;
          end
        end
        ST_SWEEP: begin
          if (last_slot) begin
            state <= ST_IDLE;
            slot  <= '0;
          end else begin
            slot <= slot + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/stb_datapath.sv =====
// ----------------------------------------------------------------------------
// stb_datapath
// Datapath: per-slot counter, period, expired flag and run bit, the slot
// update for one sweep step, the per-command slot updates, and the response register.
// ----------------------------------------------------------------------------
module stb_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  stb_pkg::ctl_cmd_t                 ctl,
  input  logic [stb_pkg::OP_W-1:0]          opcode,
  input  logic [stb_pkg::IDX_W-1:0]         timer_index,
  input  logic [stb_pkg::TIME_W-1:0]        timeout_value,
  output stb_pkg::dp_status_t               status,
  output logic                              expired
);

  logic [stb_pkg::TIME_W-1:0] tick_count   [stb_pkg::NUM_TIMERS];
  logic [stb_pkg::TIME_W-1:0] period       [stb_pkg::NUM_TIMERS];
  logic                       expired_flag [stb_pkg::NUM_TIMERS];
  logic                       running      [stb_pkg::NUM_TIMERS];

  stb_pkg::opcode_t           op;
  stb_pkg::slot_t             cmd_slot;
  logic                       idx_ok;
  logic [stb_pkg::TIME_W-1:0] count_inc;
  logic                       wrap;

  assign op             = stb_pkg::opcode_t'(opcode);
  assign cmd_slot       = stb_pkg::SLOT_W'(timer_index);
  assign idx_ok         = (32'(timer_index) < stb_pkg::NUM_TIMERS);
  assign status.is_tick = (op == stb_pkg::OP_TICK);

  // one slot of the tick sweep
  assign count_inc = tick_count[ctl.sweep_slot] + 1'b1;
  assign wrap      = (count_inc == period[ctl.sweep_slot]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < stb_pkg::NUM_TIMERS; s++) begin
        tick_count[s]   <= '0;
        period[s]       <= '0;
        expired_flag[s] <= 1'b0;
        running[s]      <= 1'b0;
      end
      expired <= 1'b0;
    end else begin
      if (ctl.sweep) begin
        if (running[ctl.sweep_slot]) begin
          tick_count[ctl.sweep_slot] <= wrap ? '0 : count_inc;
          if (wrap) begin
            expired_flag[ctl.sweep_slot] <= 1'b1;
          end
        end
      end
      if (ctl.exec) begin
        // only a check answers with the flag, everything else answers 0
        expired <= idx_ok && (op == stb_pkg::OP_CHECK) && expired_flag[cmd_slot];
        if (idx_ok) begin
          unique case (op)
            stb_pkg::OP_CREATE: begin
              if (period[cmd_slot] == '0) begin
                period[cmd_slot]       <= timeout_value;
                tick_count[cmd_slot]   <= '0;
                expired_flag[cmd_slot] <= 1'b0;
                running[cmd_slot]      <= 1'b0;
              end
            end
            stb_pkg::OP_DELETE: begin
              period[cmd_slot]       <= '0;
              tick_count[cmd_slot]   <= '0;
              expired_flag[cmd_slot] <= 1'b0;
              running[cmd_slot]      <= 1'b0;
            end
            stb_pkg::OP_START: begin
              if (period[cmd_slot] != '0) begin
                running[cmd_slot] <= 1'b1;
              end
            end
            stb_pkg::OP_STOP:  running[cmd_slot] <= 1'b0;
            stb_pkg::OP_RESET: tick_count[cmd_slot] <= '0;
            stb_pkg::OP_CHECK: expired_flag[cmd_slot] <= 1'b0;
            default: ;  // tick is handled by the sweep, unused code does nothing
          endcase
        end
      end
    end
  end

endmodule

// ===== rtl/core/multi_channel_soft_timer_bank_unit.sv =====
// ----------------------------------------------------------------------------
// multi_channel_soft_timer_bank_unit
// Bank of periodic soft timers driven by a command stream; every command
// returns one response carrying the expired bit.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                  | handshake
//  cmd     | in  | opcode[2:0] timer_index[2:0] timeout[15:0] | valid/ready
//  rsp     | out | expired                                  | valid/ready
//
//  slot commands act in the accept cycle; a tick is then carried out by the
//  sweep, which updates one slot per cycle through a single counter adder.
//  the response register is loaded in the accept cycle; cmd.ready is low
//  during a sweep and while an untaken response is held.
//  synchronous reset clears every slot and the response valid.
// ----------------------------------------------------------------------------
module multi_channel_soft_timer_bank_unit (
  input  logic      clk,
  input  logic      rst,
  stb_cmd_if.sink   cmd,
  stb_rsp_if.source rsp
);

  stb_pkg::ctl_cmd_t   ctl;
  stb_pkg::dp_status_t status;

  stb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .ctl       (ctl)
  );

  stb_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .opcode        (cmd.opcode),
    .timer_index   (cmd.timer_index),
    .timeout_value (cmd.timeout_value),
    .status        (status),
    .expired       (rsp.expired)
  );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the soft timer bank. A directed table exercises
// each command and the corner cases of the bank. It is followed by random
// create/start/tick/check sequences mixed with noise. All of this runs
// under several sender and receiver idling patterns and one long receiver
// hold-off. Every response is compared against a cycle-free model of the
// slot state.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [stb_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 4 * (stb_pkg::NUM_TIMERS + 1);
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [stb_pkg::OP_W-1:0]   op;
    logic [stb_pkg::IDX_W-1:0]  idx;
    logic [stb_pkg::TIME_W-1:0] tval;
    logic                       typed;
    logic                       exp;
  } cmd_row_t;

  localparam int NUM_ROWS = 23;

  logic clk;
  logic rst;

  stb_cmd_if cmd ();
  stb_rsp_if rsp ();

  multi_channel_soft_timer_bank_unit dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  // model copy of the bank
  logic [stb_pkg::TIME_W-1:0] slot_count   [stb_pkg::NUM_TIMERS];
  logic [stb_pkg::TIME_W-1:0] slot_period  [stb_pkg::NUM_TIMERS];
  logic                       slot_flag    [stb_pkg::NUM_TIMERS];
  logic                       slot_running [stb_pkg::NUM_TIMERS];

  logic expired_due [$];

  int tx_idle_pct;
  int rx_stall_pct;
  int hold_len;
  int items_sent;
  int responses_seen;
  int expired_seen;
  int mismatches;
  int idle_cycles;
  int input_stall_cycles;
  int hold_cycles_done;

  cmd_row_t directed_rows [NUM_ROWS] = '{
    '{stb_pkg::OP_CHECK,  3'd0, 16'h0000, 1'b1, 1'b0},  // empty bank after reset
    '{OP_UNUSED,          3'd5, 16'hffff, 1'b1, 1'b0},  // unused opcode answers 0
    '{stb_pkg::OP_CREATE, 3'd0, 16'h0001, 1'b1, 1'b0},
    '{stb_pkg::OP_START,  3'd0, 16'h0000, 1'b1, 1'b0},
    '{stb_pkg::OP_TICK,   3'd6, 16'h1234, 1'b1, 1'b0},  // tick ignores index
    '{stb_pkg::OP_CHECK,  3'd0, 16'h0000, 1'b0, 1'b0},
    '{stb_pkg::OP_CHECK,  3'd0, 16'h0000, 1'b0, 1'b0},
    '{stb_pkg::OP_CREATE, 3'd7, 16'hffff, 1'b0, 1'b0},  // longest period
    '{stb_pkg::OP_CREATE, 3'd7, 16'h0005, 1'b0, 1'b0},  // slot busy: ignored
    '{stb_pkg::OP_START,  3'd7, 16'h0000, 1'b0, 1'b0},
    '{stb_pkg::OP_TICK,   3'd0, 16'h0000, 1'b0, 1'b0},
    '{stb_pkg::OP_RESET,  3'd7, 16'h0000, 1'b0, 1'b0},
    '{stb_pkg::OP_STOP,   3'd7, 16'h0000, 1'b0, 1'b0},
    '{stb_pkg::OP_TICK,   3'd0, 16'h0000, 1'b0, 1'b0},
    '{stb_pkg::OP_CHECK,  3'd7, 16'h0000, 1'b0, 1'b0},
    '{stb_pkg::OP_CREATE, 3'd3, 16'h0000, 1'b0, 1'b0},  // zero timeout leaves slot free
    '{stb_pkg::OP_START,  3'd3, 16'h0000, 1'b0, 1'b0},
    '{stb_pkg::OP_TICK,   3'd0, 16'h0000, 1'b0, 1'b0},
    '{stb_pkg::OP_CHECK,  3'd3, 16'h0000, 1'b1, 1'b0},
    '{stb_pkg::OP_DELETE, 3'd0, 16'h0000, 1'b0, 1'b0},
    '{stb_pkg::OP_CHECK,  3'd0, 16'h0000, 1'b1, 1'b0},
    '{stb_pkg::OP_DELETE, 3'd7, 16'h0000, 1'b0, 1'b0},
    '{stb_pkg::OP_STOP,   3'd2, 16'haaaa, 1'b0, 1'b0}
  };

  // applies one command to the model and returns the expected expired bit
  function automatic logic timer_bank_step(logic [stb_pkg::OP_W-1:0]   op,
                                           logic [stb_pkg::IDX_W-1:0]  idx,
                                           logic [stb_pkg::TIME_W-1:0] tval);
    logic result;
    int s;
    result = 1'b0;
    if (op == stb_pkg::OP_TICK) begin
      for (s = 0; s < stb_pkg::NUM_TIMERS; s++) begin
        if (slot_running[s]) begin
          slot_count[s] = slot_count[s] + 1'b1;
          if (slot_count[s] == slot_period[s]) begin
            slot_count[s] = '0;
            slot_flag[s]  = 1'b1;
          end
        end
      end
    end else if (int'(idx) < stb_pkg::NUM_TIMERS) begin
      case (op)
        stb_pkg::OP_CREATE: begin
          if (slot_period[idx] == '0) begin
            slot_period[idx]  = tval;
            slot_count[idx]   = '0;
            slot_flag[idx]    = 1'b0;
            slot_running[idx] = 1'b0;
          end
        end
        stb_pkg::OP_DELETE: begin
          slot_period[idx]  = '0;
          slot_count[idx]   = '0;
          slot_flag[idx]    = 1'b0;
          slot_running[idx] = 1'b0;
        end
        stb_pkg::OP_START: begin
          if (slot_period[idx] != '0) slot_running[idx] = 1'b1;
        end
        stb_pkg::OP_STOP:  slot_running[idx] = 1'b0;
        stb_pkg::OP_RESET: slot_count[idx] = '0;
        stb_pkg::OP_CHECK: begin
          result = slot_flag[idx];
          slot_flag[idx] = 1'b0;
        end
        default: ;
      endcase
    end
    return result;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_cmd(logic [stb_pkg::OP_W-1:0] op, logic [stb_pkg::IDX_W-1:0] idx,
                          logic [stb_pkg::TIME_W-1:0] tval, logic typed, logic exp);
    logic predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd.valid = 1'b0;
      @(negedge clk);
    end
    cmd.valid         = 1'b1;
    cmd.opcode        = op;
    cmd.timer_index   = idx;
    cmd.timeout_value = tval;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    predicted = timer_bank_step(op, idx, tval);
    expired_due.push_back(typed ? exp : predicted);
    items_sent++;
    @(negedge clk);
    cmd.valid = 1'b0;
  endtask

  function automatic logic [stb_pkg::TIME_W-1:0] pick_period();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 15) return stb_pkg::TIME_W'($urandom);
    return stb_pkg::TIME_W'($urandom_range(6, 1));
  endfunction

  task automatic send_noise();
    send_cmd(stb_pkg::OP_W'($urandom_range(7)), stb_pkg::IDX_W'($urandom_range(7)),
             pick_period(), 1'b0, 1'b0);
  endtask

  // optional delete, create, start, a few ticks (some swapped for noise), then poll the same slot
  task automatic run_timer_sequence();
    logic [stb_pkg::IDX_W-1:0] slot;
    int n;
    slot = stb_pkg::IDX_W'($urandom_range(stb_pkg::NUM_TIMERS - 1));
    n = $urandom_range(8, 1);
    if ($urandom_range(1) == 0)
      send_cmd(stb_pkg::OP_DELETE, slot, stb_pkg::TIME_W'($urandom), 1'b0, 1'b0);
    send_cmd(stb_pkg::OP_CREATE, slot, pick_period(), 1'b0, 1'b0);
    send_cmd(stb_pkg::OP_START, slot, stb_pkg::TIME_W'($urandom), 1'b0, 1'b0);
    repeat (n) begin
      if ($urandom_range(9) == 0) send_noise();
      else send_cmd(stb_pkg::OP_TICK, stb_pkg::IDX_W'($urandom),
                    stb_pkg::TIME_W'($urandom), 1'b0, 1'b0);
    end
    send_cmd(stb_pkg::OP_CHECK, slot, stb_pkg::TIME_W'($urandom), 1'b0, 1'b0);
  endtask

  task automatic run_random(int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(9) < 7) run_timer_sequence();
      else send_noise();
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    int n;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
        rsp.ready = 1'b0;
        repeat (n) begin
          @(negedge clk);
          hold_cycles_done++;
        end
      end
      rsp.ready = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // response checking and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd.valid && !cmd.ready && rsp.valid && !rsp.ready) input_stall_cycles++;
      if (rsp.valid && rsp.ready) begin
        responses_seen++;
        if (expired_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: response with nothing pending, expired=%b", $realtime, rsp.expired);
        end else begin
          if (rsp.expired !== expired_due[0]) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: expired expected %b actual %b", $realtime, expired_due[0],
                       rsp.expired);
          end
          if (expired_due[0]) expired_seen++;
          void'(expired_due.pop_front());
        end
      end
      if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("multi_channel_soft_timer_bank_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int i;
    for (i = 0; i < stb_pkg::NUM_TIMERS; i++) begin
      slot_count[i]   = '0;
      slot_period[i]  = '0;
      slot_flag[i]    = 1'b0;
      slot_running[i] = 1'b0;
    end
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_len = 0;
    items_sent = 0;
    responses_seen = 0;
    expired_seen = 0;
    mismatches = 0;
    idle_cycles = 0;
    input_stall_cycles = 0;
    hold_cycles_done = 0;
    cmd.valid = 1'b0;
    cmd.opcode = stb_pkg::OP_TICK;
    cmd.timer_index = '0;
    cmd.timeout_value = '0;
    rst = 1'b1;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    for (i = 0; i < NUM_ROWS; i++)
      send_cmd(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].tval,
               directed_rows[i].typed, directed_rows[i].exp);

    // idling phases: none, sender gaps, receiver stalls, light both
    run_random(150);
    tx_idle_pct = 78;
    run_random(150);
    tx_idle_pct = 0;
    rx_stall_pct = 78;
    run_random(150);
    tx_idle_pct = 11;
    rx_stall_pct = 11;
    run_random(150);

    // long receiver hold-off while commands keep coming
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_len = 150;
    run_random(40);

    rx_stall_pct = 0;
    while (expired_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expired_due.size() != 0) mismatches++;

    $display("ran %0d commands (directed table, timer sequences, noise) under 5 idling patterns",
             items_sent);
    $display("checked %0d responses, %0d expired; %0d input stall cycles in %0d hold cycles",
             responses_seen, expired_seen, input_stall_cycles, hold_cycles_done);
    if (mismatches == 0) begin
      $display("multi_channel_soft_timer_bank_unit: match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("multi_channel_soft_timer_bank_unit: mismatch");
    end
    $finish;
  end

endmodule
